// ===== hw/rtl/saa_pkg.sv =====
`default_nettype none

package saa_pkg;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic quick;
        logic last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/shift_add_subtract_alu.sv =====
// add, subtract and divide by zero take a single step in the run state, multiply and divide
// take one step per operand bit; the result is then loaded into the output register once
// the output side is free; the single shared adder does every step, so a new item is only
// accepted while idle or as the previous result is handed over
// reset (synchronous, active low) clears the controller and the output valid flag
`default_nettype none

module shift_add_subtract_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [1:0]                   i_func,
    input  wire  signed [DATA_WIDTH-1:0] i_operand_a,
    input  wire  signed [DATA_WIDTH-1:0] i_operand_b,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_divide_by_zero
);

    saa_pkg::t_dp_cmd  cmd;
    saa_pkg::t_dp_stat stat;

    // sequencer
    saa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // arithmetic datapath
    saa_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_func           (i_func),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .o_result         (o_result),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/saa_dp.sv =====
`default_nettype none

module saa_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                         i_clk,
    input  wire  saa_pkg::t_dp_cmd      i_cmd,
    output saa_pkg::t_dp_stat           o_stat,
    input  wire  [1:0]                  i_func,
    input  wire  signed [DATA_WIDTH-1:0] i_operand_a,
    input  wire  signed [DATA_WIDTH-1:0] i_operand_b,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                        o_divide_by_zero
);

    localparam int IW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DATA_WIDTH - 1);

    // working registers
    saa_pkg::t_func          r_func;
    logic [DATA_WIDTH-1:0]   r_a;
    logic [DATA_WIDTH-1:0]   r_b;
    logic [DATA_WIDTH-1:0]   r_acc;
    logic [IW-1:0]           r_idx;

    logic [DATA_WIDTH-1:0]   n_a;
    logic [DATA_WIDTH-1:0]   n_b;
    logic [DATA_WIDTH-1:0]   n_acc;

    logic [DATA_WIDTH-1:0]   add_x;
    logic [DATA_WIDTH-1:0]   add_y;
    logic                    add_sub;
    logic [DATA_WIDTH-1:0]   add_sum;
    logic [DATA_WIDTH-1:0]   a_asr;
    logic                    div_ge;
    logic                    b_zero;

    assign b_zero = (r_b == '0);

    // dividend shifted down by the current bit position, compared signed
    assign a_asr  = DATA_WIDTH'($signed(r_a) >>> r_idx);
    assign div_ge = ($signed(a_asr) >= $signed(r_b));

    // shared adder
    assign add_sum = add_x + (add_y ^ {DATA_WIDTH{add_sub}}) + DATA_WIDTH'(add_sub);

    // operand selection for the adder
    always_comb begin
        add_x   = r_a;
        add_y   = r_b;
        add_sub = 1'b0;
        unique case (r_func)
            saa_pkg::FUNC_ADD: begin
                add_x   = r_a;
                add_y   = r_b;
                add_sub = 1'b0;
            end
            saa_pkg::FUNC_SUB: begin
                add_x   = r_a;
                add_y   = r_b;
                add_sub = 1'b1;
            end
            saa_pkg::FUNC_MUL: begin
                add_x   = r_acc;
                add_y   = r_a;
                add_sub = 1'b0;
            end
            saa_pkg::FUNC_DIV: begin
                add_x   = r_a;
                add_y   = r_b << r_idx;
                add_sub = 1'b1;
            end
            default: begin
                add_x   = r_a;
                add_y   = r_b;
                add_sub = 1'b0;
            end
        endcase
    end

    // one iteration of the selected operation
    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_acc = r_acc;
        unique case (r_func)
            saa_pkg::FUNC_ADD,
            saa_pkg::FUNC_SUB: begin
                n_acc = add_sum;
            end
            saa_pkg::FUNC_MUL: begin
                if (r_b[0]) begin
                    n_acc = add_sum;
                end
                n_a = r_a << 1;
                n_b = r_b >> 1;
            end
            saa_pkg::FUNC_DIV: begin
                if (b_zero) begin
                    n_acc = '1;
                end else if (div_ge) begin
                    n_a          = add_sum;
                    n_acc[r_idx] = 1'b1;
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    // working register update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= saa_pkg::t_func'(i_func);
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_acc  <= '0;
            r_idx  <= LAST_IDX;
        end else if (i_cmd.step) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_acc <= n_acc;
            r_idx <= r_idx - 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result         <= r_acc;
            o_divide_by_zero <= (r_func == saa_pkg::FUNC_DIV) && b_zero;
        end
    end

    // status
    assign o_stat.quick = (r_func == saa_pkg::FUNC_ADD) || (r_func == saa_pkg::FUNC_SUB)
                          || ((r_func == saa_pkg::FUNC_DIV) && b_zero);
    assign o_stat.last  = (r_idx == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/saa_ctrl.sv =====
`default_nettype none

module saa_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire                i_ready,
    input  wire saa_pkg::t_dp_stat i_stat,
    output saa_pkg::t_dp_cmd   o_cmd
);

    saa_pkg::t_state r_state;
    saa_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= saa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            saa_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = saa_pkg::S_RUN;
                end
            end
            saa_pkg::S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_stat.quick || i_stat.last) begin
                    n_state = saa_pkg::S_DONE;
                end
            end
            saa_pkg::S_DONE: begin
                // hand the result over and take the next item in the same cycle
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_ready        = 1'b1;
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = saa_pkg::S_RUN;
                    end else begin
                        n_state = saa_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = saa_pkg::S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== test/shift_add_subtract_alu_tb.sv =====
`timescale 1ns / 1ps

module shift_add_subtract_alu_tb;

    localparam int W = 32;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
    localparam int MAX_REPORTS = 10;

    // one expected result item
    typedef struct {
        logic [W-1:0] result;
        logic         div_zero;
    } t_alu_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          i_func = saa_pkg::FUNC_ADD;
    logic signed [W-1:0] i_operand_a = '0;
    logic signed [W-1:0] i_operand_b = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [W-1:0] o_result;
    logic                o_divide_by_zero;

    t_alu_result expected_results[$];
    int  error_count = 0;
    bit  idle_on = 1'b1;
    int  rx_hold = 0;
    int  rx_wait = 0;

    shift_add_subtract_alu #(
        .DATA_WIDTH(W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result        (o_result),
        .o_divide_by_zero(o_divide_by_zero)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // expected outcome of one operation
    function automatic t_alu_result predict_alu(saa_pkg::t_func f, logic [W-1:0] a,
                                                logic [W-1:0] b);
        t_alu_result         r;
        logic [W-1:0]        acc;
        logic [W-1:0]        mcand;
        logic signed [W-1:0] rem;
        logic signed [W-1:0] dvs;
        logic [W-1:0]        quo;
        r.div_zero = 1'b0;
        case (f)
            saa_pkg::FUNC_ADD: r.result = a + b;
            saa_pkg::FUNC_SUB: r.result = a - b;
            saa_pkg::FUNC_MUL: begin
                // shift-and-add over every multiplier bit
                acc = '0;
                mcand = a;
                for (int i = 0; i < W; i++) begin
                    if (b[i]) acc = acc + mcand;
                    mcand = mcand << 1;
                end
                r.result = acc;
            end
            default: begin
                if (b == '0) begin
                    r.result = ALL_ONES;
                    r.div_zero = 1'b1;
                end else begin
                    // restoring loop, signed compare, wrapping subtract
                    rem = a;
                    dvs = b;
                    quo = '0;
                    for (int i = W - 1; i >= 0; i--) begin
                        if ((rem >>> i) >= dvs) begin
                            quo[i] = 1'b1;
                            rem = rem - (dvs << i);
                        end
                    end
                    r.result = quo;
                end
            end
        endcase
        return r;
    endfunction

    // offer one item, hold it until accepted, then log its expected result
    task automatic send_op(saa_pkg::t_func f, logic [W-1:0] a, logic [W-1:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(predict_alu(f, a, b));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // operand mix: extremes, small values, powers of two, 16-bit values and full-range words
    function automatic logic [W-1:0] draw_operand();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return 1;
                    2: return ALL_ONES;
                    3: return MAX_POS;
                    default: return MIN_NEG;
                endcase
            end
            1: return $signed($urandom_range(0, 40)) - 20;
            2: return {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W - 1);
            3: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic saa_pkg::t_func draw_func();
        return saa_pkg::t_func'($urandom_range(0, 3));
    endfunction

    // result side: random stalls, long hold on request, check of each item
    initial begin
        t_alu_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result item: result=%h div_zero=%b",
                                 o_result, o_divide_by_zero);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result !== want.result || o_divide_by_zero !== want.div_zero) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch: result exp %h got %h, div_zero exp %b got %b",
                                     want.result, o_result, want.div_zero, o_divide_by_zero);
                    end
                end
                rx_wait = idle_on ? $urandom_range(0, 10) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (rx_hold > 0) rx_hold--;
            i_ready <= i_rst_n && (rx_wait == 0) && (rx_hold == 0);
        end
    end

    // extremes of add and subtract
    task automatic test_add_sub();
        send_op(saa_pkg::FUNC_ADD, '0, '0);
        send_op(saa_pkg::FUNC_ADD, MAX_POS, 1);
        send_op(saa_pkg::FUNC_ADD, MIN_NEG, MIN_NEG);
        send_op(saa_pkg::FUNC_ADD, ALL_ONES, 1);
        send_op(saa_pkg::FUNC_ADD, ALL_ONES, ALL_ONES);
        send_op(saa_pkg::FUNC_SUB, MIN_NEG, 1);
        send_op(saa_pkg::FUNC_SUB, MAX_POS, MIN_NEG);
        send_op(saa_pkg::FUNC_SUB, '0, MIN_NEG);
        send_op(saa_pkg::FUNC_SUB, '0, '0);
        send_op(saa_pkg::FUNC_SUB, '0, ALL_ONES);
    endtask

    // multiply, negative multiplier included
    task automatic test_multiply();
        send_op(saa_pkg::FUNC_MUL, '0, ALL_ONES);
        send_op(saa_pkg::FUNC_MUL, ALL_ONES, ALL_ONES);
        send_op(saa_pkg::FUNC_MUL, MAX_POS, MAX_POS);
        send_op(saa_pkg::FUNC_MUL, MIN_NEG, ALL_ONES);
        send_op(saa_pkg::FUNC_MUL, 7, -3);
        send_op(saa_pkg::FUNC_MUL, 1, MIN_NEG);
    endtask

    // divide: zero divisor, exact cases and signed corners
    task automatic test_divide();
        send_op(saa_pkg::FUNC_DIV, '0, '0);
        send_op(saa_pkg::FUNC_DIV, MIN_NEG, '0);
        send_op(saa_pkg::FUNC_DIV, 100, 7);
        send_op(saa_pkg::FUNC_DIV, 3, 10);
        send_op(saa_pkg::FUNC_DIV, MAX_POS, 1);
        send_op(saa_pkg::FUNC_DIV, -100, 7);
        send_op(saa_pkg::FUNC_DIV, 100, -7);
        send_op(saa_pkg::FUNC_DIV, MIN_NEG, ALL_ONES);
        send_op(saa_pkg::FUNC_DIV, MAX_POS, MIN_NEG);
    endtask

    // mixed operations with random gaps on both sides
    task automatic test_random_mix(int n);
        for (int k = 0; k < n; k++) send_op(draw_func(), draw_operand(), draw_operand());
    endtask

    // back to back traffic, no idling anywhere
    task automatic test_no_idle(int n);
        idle_on = 1'b0;
        for (int k = 0; k < n; k++) send_op(draw_func(), draw_operand(), draw_operand());
        idle_on = 1'b1;
    endtask

    // divides with non-negative dividend and positive divisor
    task automatic test_exact_divide(int n);
        logic [W-1:0] a;
        logic [W-1:0] b;
        for (int k = 0; k < n; k++) begin
            a = $urandom & MAX_POS;
            b = ($urandom & MAX_POS) >> $urandom_range(0, W - 2);
            if (b == '0) b = 1;
            send_op(saa_pkg::FUNC_DIV, a, b);
        end
    endtask

    // long receiver hold fills the block, then the sender waits for a full drain
    task automatic test_backpressure();
        rx_hold = 300;
        idle_on = 1'b0;
        for (int k = 0; k < 30; k++)
            send_op(saa_pkg::t_func'($urandom_range(0, 1)), $urandom, $urandom);
        for (int k = 0; k < 10; k++) send_op(draw_func(), draw_operand(), draw_operand());
        idle_on = 1'b1;
        wait_drained();
        for (int k = 0; k < 20; k++)
            send_op(saa_pkg::FUNC_MUL, draw_operand(), draw_operand());
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_add_sub();
        test_multiply();
        test_divide();
        test_random_mix(900);
        test_no_idle(300);
        test_backpressure();
        test_exact_divide(250);
        test_random_mix(340);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("shift_add_subtract_alu_tb OK");
        end else begin
            $display("shift_add_subtract_alu_tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #6_000_000;
        $display("shift_add_subtract_alu_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/saa_pkg.sv
hw/rtl/saa_dp.sv
hw/rtl/saa_ctrl.sv
hw/rtl/shift_add_subtract_alu.sv
test/shift_add_subtract_alu_tb.sv
